[rtl/core/lz_nearest_longer_match_finder_defines.svh]
// assertion macros for the checker of the match finder
`ifndef LZ_NEAREST_LONGER_MATCH_FINDER_DEFINES_SVH
`define LZ_NEAREST_LONGER_MATCH_FINDER_DEFINES_SVH

// same-cycle implication, off during reset
`define LZNM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lznm check failed: label");

// next-cycle implication, off during reset
`define LZNM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lznm check failed: label");

// next-cycle implication that also watches reset itself
`define LZNM_ASSERT_RESET_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("lznm check failed: label");

`endif

[rtl/core/lznm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lznm_pkg;

   // fixed field widths
   localparam int REQ_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 14;
   localparam int MINLEN_W = 9;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 14;
   localparam int CODE_W   = 8;

   // default sizing
   localparam int DEFAULT_BUFFER_DEPTH = 16384;
   localparam int DEFAULT_MAX_MATCH    = 256;

   // request codes
   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [BYTE_W-1:0]   byte_value;
      logic [POS_W-1:0]    position;
      logic [MINLEN_W-1:0] min_length;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   literal_value;
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
      logic [CODE_W-1:0]   length_code;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LITERAL,
      ST_PAIR,
      ST_EXTEND,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

[rtl/core/lznm_source_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lznm_source_ram #(
   parameter int DEPTH = lznm_pkg::DEFAULT_BUFFER_DEPTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [lznm_pkg::BYTE_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr_a,
   input  wire logic [AW-1:0]             rd_addr_b,
   output logic [lznm_pkg::BYTE_W-1:0]    rd_data_a,
   output logic [lznm_pkg::BYTE_W-1:0]    rd_data_b
);

   logic [lznm_pkg::BYTE_W-1:0] store_ff [DEPTH];
   logic [lznm_pkg::BYTE_W-1:0] rd_data_a_ff;
   logic [lznm_pkg::BYTE_W-1:0] rd_data_b_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      rd_data_a_ff <= store_ff[rd_addr_a];
      rd_data_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

[rtl/core/lznm_match_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module lznm_match_engine #(
   parameter int BUFFER_DEPTH = lznm_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int MAX_MATCH    = lznm_pkg::DEFAULT_MAX_MATCH,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire lznm_pkg::req_word_type      req_word,
   output logic                             req_stall,
   input  wire logic                        out_free,
   output logic                             res_load,
   output lznm_pkg::rsp_word_type           res_word,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [lznm_pkg::BYTE_W-1:0]      wr_data,
   output logic [AW-1:0]                    rd_addr_a,
   output logic [AW-1:0]                    rd_addr_b,
   input  wire logic [lznm_pkg::BYTE_W-1:0] rd_data_a,
   input  wire logic [lznm_pkg::BYTE_W-1:0] rd_data_b
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int LW = $clog2(MAX_MATCH + 1);
   localparam int IW = (CW > lznm_pkg::POS_W) ? CW : lznm_pkg::POS_W;

   lznm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] j_ff, j_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] cap_ff, cap_in;
   logic [lznm_pkg::MINLEN_W-1:0] min_ff, min_in;
   logic [lznm_pkg::BYTE_W-1:0] lit_ff, lit_in;
   logic [lznm_pkg::BYTE_W-1:0] b1_ff, b1_in;
   lznm_pkg::rsp_word_type result_ff, result_in;

   logic [CW-1:0] remain;
   logic [LW-1:0] cap_now;
   logic [LW-1:0] len_next;
   logic [LW-1:0] cand_len;
   logic          cand_end;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lznm_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // query working registers
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      j_ff      <= j_in;
      len_ff    <= len_in;
      cap_ff    <= cap_in;
      min_ff    <= min_in;
      lit_ff    <= lit_in;
      b1_ff     <= b1_in;
      result_ff <= result_in;
   end

   // sequencer: accept, literal fetch, pair scan, extension, result
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      j_in      = j_ff;
      len_in    = len_ff;
      cap_in    = cap_ff;
      min_in    = min_ff;
      lit_in    = lit_ff;
      b1_in     = b1_ff;
      result_in = result_ff;
      req_stall = 1'b1;
      res_load  = 1'b0;
      res_word  = result_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(count_ff);
      wr_data   = req_word.byte_value;
      rd_addr_a = '0;
      rd_addr_b = '0;
      remain    = count_ff - CW'(pos_ff);
      cap_now   = (remain < CW'(MAX_MATCH)) ? LW'(remain) : LW'(MAX_MATCH);
      len_next  = len_ff + LW'(1);
      cand_len  = '0;
      cand_end  = 1'b0;

      unique case (state_ff)
         lznm_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               res_word = '0;
               unique case (req_word.req_type)
                  lznm_pkg::REQ_CLEAR: begin
                     count_in = '0;
                     res_load = 1'b1;
                  end
                  lznm_pkg::REQ_APPEND: begin
                     res_load = 1'b1;
                     if (count_ff == CW'(BUFFER_DEPTH)) begin
                        res_word.status = lznm_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  lznm_pkg::REQ_QUERY: begin
                     if (IW'(req_word.position) >= IW'(count_ff)) begin
                        res_load        = 1'b1;
                        res_word.status = lznm_pkg::STATUS_BEYOND;
                     end else begin
                        pos_in    = AW'(req_word.position);
                        min_in    = req_word.min_length;
                        rd_addr_a = AW'(req_word.position);
                        rd_addr_b = AW'(req_word.position) + AW'(1);
                        state_in  = lznm_pkg::ST_LITERAL;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end

         lznm_pkg::ST_LITERAL: begin
            lit_in    = rd_data_a;
            b1_in     = rd_data_b;
            cap_in    = cap_now;
            result_in = '0;
            result_in.literal_value = rd_data_a;
            // no pair, no earlier position, or nothing long enough can fit
            if (remain <= CW'(1) || pos_ff == '0 ||
                lznm_pkg::MINLEN_W'(cap_now) <= min_ff) begin
               state_in = lznm_pkg::ST_RESULT;
            end else begin
               j_in      = pos_ff - AW'(1);
               rd_addr_a = pos_ff - AW'(1);
               rd_addr_b = pos_ff;
               state_in  = lznm_pkg::ST_PAIR;
            end
         end

         lznm_pkg::ST_PAIR: begin
            if (rd_data_a == lit_ff && rd_data_b == b1_ff) begin
               len_in = LW'(2);
               if (cap_ff <= LW'(2)) begin
                  cand_end = 1'b1;
                  cand_len = LW'(2);
               end else begin
                  rd_addr_a = pos_ff + AW'(2);
                  rd_addr_b = j_ff + AW'(2);
                  state_in  = lznm_pkg::ST_EXTEND;
               end
            end else begin
               cand_end = 1'b1;
            end
         end

         lznm_pkg::ST_EXTEND: begin
            if (rd_data_a == rd_data_b && len_next < cap_ff) begin
               len_in    = len_next;
               rd_addr_a = pos_ff + AW'(len_next);
               rd_addr_b = j_ff + AW'(len_next);
            end else begin
               cand_end = 1'b1;
               cand_len = (rd_data_a == rd_data_b) ? len_next : len_ff;
            end
         end

         lznm_pkg::ST_RESULT: begin
            res_load = out_free;
            if (out_free) begin
               state_in = lznm_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lznm_pkg::ST_IDLE;
         end
      endcase

      // candidate finished: report it, step one position back, or end with no match
      if (cand_end) begin
         result_in = '0;
         result_in.literal_value = lit_ff;
         if (lznm_pkg::MINLEN_W'(cand_len) > min_ff) begin
            result_in.found        = 1'b1;
            result_in.match_offset = lznm_pkg::OFFSET_W'(pos_ff - j_ff);
            result_in.length_code  = lznm_pkg::CODE_W'(cand_len - LW'(1));
            state_in = lznm_pkg::ST_RESULT;
         end else if (j_ff == '0) begin
            state_in = lznm_pkg::ST_RESULT;
         end else begin
            j_in      = j_ff - AW'(1);
            rd_addr_a = j_ff - AW'(1);
            rd_addr_b = j_ff;
            state_in  = lznm_pkg::ST_PAIR;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/lz_nearest_longer_match_finder.sv]
// LZ match finder over a byte buffer loaded one byte at a time.
// Request channel (req_valid / req_stall / req_word): clear the buffer,
// append a byte, or query a position with a minimum length.
// Result channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
// request, in request order, held in an output register.
// Clear, append, unused codes and out-of-range queries: the result word is
// loaded into the output register on acceptance.
// Query: the literal pair is fetched first, then each earlier candidate
// position gets a pair check and each candidate that agrees on the pair is
// compared byte by byte, then the result goes to the output register.
// The search speed is set by the two read ports of the source memory: one
// candidate or one byte pair is compared per cycle.
// A new request is taken only when the sequencer is idle and the output
// register is empty or being drained.
// Reset empties the buffer count and the output register; the buffer memory
// itself is not cleared and needs no clearing pass.
// While rsp_valid and rsp_stall are both high the result word holds and requests stall.
`timescale 1ns / 1ps
`default_nettype none

module lz_nearest_longer_match_finder #(
   parameter int BUFFER_DEPTH = lznm_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int MAX_MATCH    = lznm_pkg::DEFAULT_MAX_MATCH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lznm_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lznm_pkg::rsp_word_type      rsp_word
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic                        out_free;
   logic                        res_load;
   lznm_pkg::rsp_word_type      res_word;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [lznm_pkg::BYTE_W-1:0] wr_data;
   logic [AW-1:0]               rd_addr_a;
   logic [AW-1:0]               rd_addr_b;
   logic [lznm_pkg::BYTE_W-1:0] rd_data_a;
   logic [lznm_pkg::BYTE_W-1:0] rd_data_b;

   logic                   rsp_valid_ff, rsp_valid_in;
   lznm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   lznm_source_ram #(
      .DEPTH(BUFFER_DEPTH)
   ) u_source_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   lznm_match_engine #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .MAX_MATCH   (MAX_MATCH)
   ) u_match_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .out_free  (out_free),
      .res_load  (res_load),
      .res_word  (res_word),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // output register, free when empty or taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

[rtl/core/lznm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "lz_nearest_longer_match_finder_defines.svh"

module lznm_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire lznm_pkg::req_word_type req_word,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire lznm_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   `LZNM_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // reset empties the output register
   `LZNM_ASSERT_RESET_NEXT(rsp_empty_after_reset, reset, !rsp_valid)

   // a blocked output blocks new requests
   `LZNM_ASSERT_IMPL(req_blocked_by_output, rsp_valid && rsp_stall, req_stall)

   // a found match has a real distance and length on an ok status
   `LZNM_ASSERT_IMPL(found_fields, rsp_valid && rsp_word.found, rsp_word.match_offset != 0 && rsp_word.length_code != 0 && rsp_word.status == lznm_pkg::STATUS_OK)

   // no match, no distance or length
   `LZNM_ASSERT_IMPL(miss_fields, rsp_valid && !rsp_word.found, rsp_word.match_offset == 0 && rsp_word.length_code == 0)

endmodule

bind lz_nearest_longer_match_finder lznm_checker u_lznm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

[tb/lz_match_result_checker.sv]
`timescale 1ns / 1ps

// watches both channels of the match finder, predicts every result word from
// the accepted request words and compares them in order
module lz_match_result_checker #(
   parameter int BUFFER_DEPTH = lznm_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int MAX_MATCH    = lznm_pkg::DEFAULT_MAX_MATCH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire lznm_pkg::req_word_type req_word,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire lznm_pkg::rsp_word_type rsp_word,
   output int unsigned                 fail_count,
   output int unsigned                 pending_words
);

   // mirror of the source buffer and its fill level
   logic [lznm_pkg::BYTE_W-1:0] source_bytes [BUFFER_DEPTH];
   int unsigned                 loaded_len;

   lznm_pkg::rsp_word_type awaited_results [$];
   int unsigned            mismatches = 0;

   assign fail_count = mismatches;

   // result of one request, updating the mirrored buffer on the way
   function automatic lznm_pkg::rsp_word_type match_result_for(
      input lznm_pkg::req_word_type w);
      lznm_pkg::rsp_word_type r;
      int unsigned  pos;
      int unsigned  cap;
      int unsigned  run;
      int unsigned  j;
      logic [lznm_pkg::BYTE_W-1:0] lead;
      logic [lznm_pkg::BYTE_W-1:0] trail;
      r = '0;
      r.status = lznm_pkg::STATUS_OK;
      case (w.req_type)
         lznm_pkg::REQ_CLEAR: begin
            loaded_len = 0;
         end
         lznm_pkg::REQ_APPEND: begin
            if (loaded_len >= BUFFER_DEPTH) begin
               r.status = lznm_pkg::STATUS_FULL;
            end else begin
               source_bytes[loaded_len] = w.byte_value;
               loaded_len++;
            end
         end
         lznm_pkg::REQ_QUERY: begin
            pos = w.position;
            if (pos >= loaded_len) begin
               r.status = lznm_pkg::STATUS_BEYOND;
            end else begin
               r.literal_value = source_bytes[pos];
               // the last loaded byte has no pair to match on
               if (pos + 1 < loaded_len) begin
                  cap = loaded_len - pos;
                  if (cap > MAX_MATCH) cap = MAX_MATCH;
                  lead  = source_bytes[pos];
                  trail = source_bytes[pos + 1];
                  j = pos;
                  // nearest candidate first, stop at the first long enough run
                  while (j > 0 && !r.found) begin
                     j--;
                     if (source_bytes[j] == lead && source_bytes[j + 1] == trail) begin
                        run = 2;
                        while (run < cap && source_bytes[pos + run] == source_bytes[j + run])
                           run++;
                        if (run > int'(w.min_length)) begin
                           r.found        = 1'b1;
                           r.match_offset = lznm_pkg::OFFSET_W'(pos - j);
                           r.length_code  = lznm_pkg::CODE_W'(run - 1);
                        end
                     end
                  end
               end
            end
         end
         default: begin
            // unused code: no state change, all-zero word
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // result words are checked before the request of the same edge is queued
   always @(posedge clock) begin
      lznm_pkg::rsp_word_type want;
      if (reset) begin
         awaited_results.delete();
         loaded_len = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result word %h with no request outstanding", rsp_word);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", want.status, rsp_word.status);
               compare_field("literal_value", want.literal_value, rsp_word.literal_value);
               compare_field("found", want.found, rsp_word.found);
               compare_field("match_offset", want.match_offset, rsp_word.match_offset);
               compare_field("length_code", want.length_code, rsp_word.length_code);
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(match_result_for(req_word));
      end
      pending_words <= awaited_results.size();
   end

endmodule

[tb/lz_nearest_longer_match_finder_tb.sv]
`timescale 1ns / 1ps

module lz_nearest_longer_match_finder_tb;

   localparam int BUFFER_DEPTH = lznm_pkg::DEFAULT_BUFFER_DEPTH;
   localparam int MAX_MATCH    = lznm_pkg::DEFAULT_MAX_MATCH;
   localparam int RANDOM_ITEMS = 290;
   localparam int LONG_HOLD    = 400;
   localparam int RUN_LIMIT    = 3000000;
   localparam logic [lznm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   lznm_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   lznm_pkg::rsp_word_type rsp_word;

   int unsigned fail_count;
   int unsigned pending_words;
   int unsigned cycle_count       = 0;
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned fill_level        = 0;
   int unsigned random_items      = 0;
   bit          hold_pending      = 1'b0;

   always #1 clock = ~clock;

   lz_nearest_longer_match_finder #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_MATCH    (MAX_MATCH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   lz_match_result_checker #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .MAX_MATCH    (MAX_MATCH)
   ) result_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // offer one request word, with random gaps, until it is taken
   task automatic issue(input logic [lznm_pkg::REQ_W-1:0] kind, input int unsigned value,
                        input int unsigned pos, input int unsigned min_len);
      lznm_pkg::req_word_type w;
      w.req_type   = kind;
      w.byte_value = value[lznm_pkg::BYTE_W-1:0];
      w.position   = pos[lznm_pkg::POS_W-1:0];
      w.min_length = min_len[lznm_pkg::MINLEN_W-1:0];
      case (kind)
         lznm_pkg::REQ_CLEAR:  fill_level = 0;
         lznm_pkg::REQ_APPEND: if (fill_level < BUFFER_DEPTH) fill_level++;
         default:    ;
      endcase
      if (kind != REQ_UNUSED) random_items++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sender pause until every result word is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   // one load of the buffer followed by chains of queries on it
   task automatic random_segment();
      int unsigned n;
      int unsigned alphabet;
      int unsigned base;
      int unsigned pos;
      int unsigned min_len;
      int unsigned chain;
      if (fill_level > 120 || $urandom_range(9) != 0)
         issue(lznm_pkg::REQ_CLEAR, $urandom, $urandom, $urandom);
      n = ($urandom_range(19) == 0) ? $urandom_range(80, 140) : $urandom_range(2, 40);
      alphabet = ($urandom_range(3) == 0) ? 256 : $urandom_range(1, 4);
      base = $urandom_range(255);
      repeat (n)
         issue(lznm_pkg::REQ_APPEND, base + $urandom_range(alphabet - 1), $urandom, $urandom);
      repeat ($urandom_range(1, 6)) begin
         pos = $urandom_range(fill_level - 1);
         min_len = 1;
         chain = $urandom_range(1, 4);
         repeat (chain) begin
            issue(lznm_pkg::REQ_QUERY, $urandom, pos, min_len);
            min_len += $urandom_range(1, 8);
         end
      end
      // noise: unused codes, wild queries, stray appends
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(2))
            0: issue(REQ_UNUSED, $urandom, $urandom, $urandom);
            1: issue(lznm_pkg::REQ_QUERY, $urandom, $urandom, $urandom_range(511));
            default: issue(lznm_pkg::REQ_APPEND, $urandom, $urandom, $urandom);
         endcase
      end
      if ($urandom_range(7) == 0) wait_for_results();
   endtask

   initial begin
      int unsigned phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty buffer, unused code
      issue(REQ_UNUSED, 8'hff, 14'h3fff, 9'h1ff);
      issue(lznm_pkg::REQ_QUERY, 0, 0, 1);
      issue(lznm_pkg::REQ_CLEAR, 0, 0, 0);

      // overlapping repeat 00 ff 00 ff 00 ff 00
      for (int k = 0; k < 7; k++)
         issue(lznm_pkg::REQ_APPEND, (k % 2) ? 8'hff : 8'h00, 0, 0);
      issue(lznm_pkg::REQ_QUERY, 0, 2, 1);
      issue(lznm_pkg::REQ_QUERY, 0, 2, 4);
      issue(lznm_pkg::REQ_QUERY, 0, 2, 5);
      issue(lznm_pkg::REQ_QUERY, 0, 2, 0);
      issue(lznm_pkg::REQ_QUERY, 0, 1, 1);
      issue(lznm_pkg::REQ_QUERY, 0, 6, 1);
      issue(lznm_pkg::REQ_QUERY, 0, 7, 1);
      issue(lznm_pkg::REQ_QUERY, 0, 3, 511);
      issue(lznm_pkg::REQ_QUERY, 0, 0, 1);
      issue(REQ_UNUSED, 8'h5a, 14'h2aaa, 9'h155);
      issue(lznm_pkg::REQ_CLEAR, 8'hff, 14'h3fff, 9'h1ff);
      issue(lznm_pkg::REQ_QUERY, 0, 0, 1);

      // long run of one byte: match length capped at the maximum
      repeat (260) issue(lznm_pkg::REQ_APPEND, 8'ha5, 0, 0);
      issue(lznm_pkg::REQ_QUERY, 0, 1, 1);
      issue(lznm_pkg::REQ_QUERY, 0, 1, 255);
      issue(lznm_pkg::REQ_QUERY, 0, 1, 256);
      issue(lznm_pkg::REQ_QUERY, 0, 259, 1);
      issue(lznm_pkg::REQ_CLEAR, 0, 0, 0);
      wait_for_results();

      // random part in three idling phases
      random_items = 0;
      phase = 0;
      sender_idle_pct   = 32;
      receiver_idle_pct = 80;
      while (random_items < RANDOM_ITEMS) begin
         if (phase == 0 && random_items >= RANDOM_ITEMS / 3) begin
            wait_for_results();
            sender_idle_pct   = 80;
            receiver_idle_pct = 32;
            phase = 1;
         end else if (phase == 1 && random_items >= 2 * RANDOM_ITEMS / 3) begin
            wait_for_results();
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
            hold_pending = 1'b1;
            phase = 2;
         end
         random_segment();
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
